// ----- hdl/life_pkg.sv -----
// shared types and constants for the life board
package life_pkg;

  // configuration register layout
  localparam int CFG_W           = 7;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_SIZE_RESET  = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_HEIGHT = 1'b1;

  // payload field widths
  localparam int ACTION_W = 2;
  localparam int ROW_W    = 6;
  localparam int COLUMN_W = 6;

  // default board limits
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // life rule B3/S23
  localparam int NB_COUNT_W  = 4;
  localparam logic [NB_COUNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [NB_COUNT_W-1:0] STAY_COUNT  = 4'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // control broadcast from the sequencer to every column cell
  typedef struct packed {
    logic rotate;
    logic sweep_upd;
    logic below_ok;
    logic clr_above;
    logic wr_en;
    logic wr_val;
  } cell_ctl_t;

endpackage

// ----- hdl/life_cell.sv -----
// one column of the board, held as a circulating shift register of rows
module life_cell #(
  parameter int MAX_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  life_pkg::cell_ctl_t ctl,
  input  logic                col_use,
  input  logic                wr_sel,
  input  logic [2:0]          nb_left,
  input  logic [2:0]          nb_right,
  output logic [2:0]          nb_out,
  output logic                head_bit,
  output logic                change
);
  import life_pkg::*;

  logic [MAX_HEIGHT-1:0] col_r, col_nxt;
  logic                  above_r, above_nxt;
  logic                  centre, below;
  logic [NB_COUNT_W-1:0] n_count;
  logic                  next_live;
  logic                  upd;
  logic                  head_val;

  // the row at position 0 is the one being looked at
  assign centre   = col_r[0];
  assign below    = ctl.below_ok & col_r[1];
  assign head_bit = centre;

  // bits handed to the neighbouring columns, dead when this column is unused
  assign nb_out = {above_r, centre, below} & {3{col_use}};

  // live neighbour count
  always_comb begin
    n_count = NB_COUNT_W'(nb_left[0]) + NB_COUNT_W'(nb_left[1]) + NB_COUNT_W'(nb_left[2])
            + NB_COUNT_W'(nb_right[0]) + NB_COUNT_W'(nb_right[1])
            + NB_COUNT_W'(nb_right[2]) + NB_COUNT_W'(above_r) + NB_COUNT_W'(below);
  end

  // rule: birth on three, survival on two or three
  assign next_live = (n_count == BIRTH_COUNT) || (centre && (n_count == STAY_COUNT));
  assign upd       = ctl.sweep_upd & col_use;
  assign head_val  = upd ? next_live : centre;
  assign change    = upd & (next_live != centre);

  // column update: rotate, or write the head row in place; the above bit can also be cleared
  always_comb begin
    col_nxt   = col_r;
    above_nxt = above_r;
    if (ctl.rotate) begin
      col_nxt   = {head_val, col_r[MAX_HEIGHT-1:1]};
      above_nxt = centre;
    end else if (ctl.wr_en && wr_sel) begin
      col_nxt[0] = ctl.wr_val;
    end
    if (ctl.clr_above) begin
      above_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      above_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      above_r <= above_nxt;
    end
  end

endmodule

// ----- hdl/life_ctrl.sv -----
// sequencer: takes items, aligns the board rows, runs the generation sweep
module life_ctrl #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int CW_W       = 7,
  parameter int CH_W       = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [life_pkg::ACTION_W-1:0]  in_action,
  input  logic [life_pkg::ROW_W-1:0]     in_row,
  input  logic [life_pkg::COLUMN_W-1:0]  in_column,
  input  logic                           in_cell_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_read_value,
  output logic                           out_changed,
  input  logic [CW_W-1:0]                used_cols,
  input  logic [CH_W-1:0]                used_rows,
  input  logic                           rd_bit,
  input  logic                           any_change,
  output logic [$clog2(MAX_WIDTH)-1:0]   sel_col,
  output life_pkg::cell_ctl_t            ctl
);
  import life_pkg::*;

  localparam int RI_W = $clog2(MAX_HEIGHT);
  localparam int CI_W = $clog2(MAX_WIDTH);
  localparam logic [RI_W-1:0] LAST_ROW = RI_W'(MAX_HEIGHT - 1);

  state_t          state_r, state_nxt;
  action_t         act_r, act_nxt, in_act;
  logic [RI_W-1:0] head_r, head_nxt;
  logic [RI_W-1:0] target_r, target_nxt;
  logic [RI_W-1:0] sweep_r, sweep_nxt;
  logic [CI_W-1:0] col_r, col_nxt;
  logic            val_r, val_nxt;
  logic            rd_r, rd_nxt;
  logic            changed_r, changed_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_rd_r, out_rd_nxt;
  logic            out_ch_r, out_ch_nxt;
  logic [CH_W-1:0] row_ext;
  logic [CW_W-1:0] col_ext;
  logic            on_board;
  logic            needs_seek;
  logic            at_target;
  logic            out_free;
  logic            in_xfer;

  assign in_act   = action_t'(in_action);
  assign row_ext  = CH_W'(in_row);
  assign col_ext  = CW_W'(in_column);
  assign on_board = (row_ext < used_rows) && (col_ext < used_cols);
  assign in_xfer  = in_valid && (state_r == ST_IDLE);
  assign at_target = (head_r == target_r);
  assign out_free = !out_valid_r || !out_stall;
  assign sel_col  = col_r;

  // reads and writes off the board, and the unused action, need no board access
  always_comb begin
    unique case (in_act)
      ACT_WRITE, ACT_READ: needs_seek = on_board;
      ACT_STEP:            needs_seek = 1'b1;
      default:             needs_seek = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = needs_seek ? ST_SEEK : ST_FINISH;
        end
      end
      ST_SEEK: begin
        if (at_target) begin
          state_nxt = (act_r == ACT_STEP) ? ST_SWEEP : ST_FINISH;
        end
      end
      ST_SWEEP: begin
        if (sweep_r == LAST_ROW) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    ctl.rotate    = ((state_r == ST_SEEK) && !at_target) || (state_r == ST_SWEEP);
    ctl.sweep_upd = (state_r == ST_SWEEP) && (CH_W'(sweep_r) < used_rows);
    ctl.below_ok  = (state_r == ST_SWEEP) && ((CH_W'(sweep_r) + 1'b1) < used_rows);
    ctl.clr_above = (state_r == ST_SEEK) && at_target && (act_r == ACT_STEP);
    ctl.wr_en     = (state_r == ST_SEEK) && at_target && (act_r == ACT_WRITE);
    ctl.wr_val    = val_r;
  end

  // item registers, row pointer and result
  always_comb begin
    act_nxt       = act_r;
    target_nxt    = target_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    rd_nxt        = rd_r;
    changed_nxt   = changed_r;
    sweep_nxt     = sweep_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rd_nxt    = out_rd_r;
    out_ch_nxt    = out_ch_r;

    if (in_xfer) begin
      act_nxt     = in_act;
      target_nxt  = (in_act == ACT_STEP) ? '0 : row_ext[RI_W-1:0];
      col_nxt     = col_ext[CI_W-1:0];
      val_nxt     = in_cell_value;
      rd_nxt      = 1'b0;
      changed_nxt = 1'b0;
    end

    // the row pointer follows every rotation
    if (ctl.rotate) begin
      head_nxt = (head_r == LAST_ROW) ? '0 : head_r + 1'b1;
    end

    if ((state_r == ST_SEEK) && at_target && (act_r == ACT_READ)) begin
      rd_nxt = rd_bit;
    end

    if (state_r == ST_SWEEP) begin
      changed_nxt = changed_r | any_change;
      sweep_nxt   = (sweep_r == LAST_ROW) ? '0 : sweep_r + 1'b1;
    end

    if ((state_r == ST_FINISH) && out_free) begin
      out_valid_nxt = 1'b1;
      out_rd_nxt    = rd_r;
      out_ch_nxt    = changed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    target_r  <= target_nxt;
    col_r     <= col_nxt;
    val_r     <= val_nxt;
    rd_r      <= rd_nxt;
    changed_r <= changed_nxt;
    out_rd_r  <= out_rd_nxt;
    out_ch_r  <= out_ch_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_changed    = out_ch_r;

endmodule

// ----- hdl/life_cellular_automaton_board.sv -----
// top level of the life board: configuration, column cells and sequencer
//
// Conway Life board (B3/S23) of MAX_HEIGHT x MAX_WIDTH one-bit cells with a
// dead border, one result per item. Each column is a cell holding its rows in
// a circulating shift register; all columns rotate together, so the row at
// the head is the one that can be read, written or updated. A write or read
// on the board first rotates the head forward to the addressed row. A step
// rotates the head to row 0 and then updates one whole row per cycle until
// every row has passed the head. Reads and writes off the board in use, and
// the unused action, go straight to the result without rotating. A new item
// is taken once the previous one has reached the output register, even while
// that result waits. All cells reset dead; no clearing pass is needed.
module life_cellular_automaton_board #(
  parameter int MAX_WIDTH  = life_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = life_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [life_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [life_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [life_pkg::ACTION_W-1:0]       in_action,
  input  logic [life_pkg::ROW_W-1:0]          in_row,
  input  logic [life_pkg::COLUMN_W-1:0]       in_column,
  input  logic                                in_cell_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_read_value,
  output logic                                out_changed
);
  import life_pkg::*;

  localparam int CW_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int CH_W = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int CI_W = $clog2(MAX_WIDTH);

  logic [CFG_W-1:0]     board_width_r, board_width_nxt;
  logic [CFG_W-1:0]     board_height_r, board_height_nxt;
  logic [CW_W-1:0]      width_ext, used_cols;
  logic [CH_W-1:0]      height_ext, used_rows;
  logic [MAX_WIDTH-1:0] col_use, wr_sel, head_bits, change_bits;
  logic [2:0]           nb_bits [MAX_WIDTH];
  logic [CI_W-1:0]      sel_col;
  logic                 rd_bit;
  logic                 any_change;
  cell_ctl_t            ctl;

  // configuration registers
  always_comb begin
    board_width_nxt  = board_width_r;
    board_height_nxt = board_height_r;
    if (cfg_wr_en) begin
      if (cfg_index == CFG_BOARD_WIDTH) begin
        board_width_nxt = cfg_wdata;
      end
      if (cfg_index == CFG_BOARD_HEIGHT) begin
        board_height_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_width_r  <= CFG_W'(CFG_SIZE_RESET);
      board_height_r <= CFG_W'(CFG_SIZE_RESET);
    end else begin
      board_width_r  <= board_width_nxt;
      board_height_r <= board_height_nxt;
    end
  end

  // sizes in use, clipped to the board limits
  assign width_ext  = CW_W'(board_width_r);
  assign height_ext = CH_W'(board_height_r);
  assign used_cols  = (width_ext > CW_W'(MAX_WIDTH)) ? CW_W'(MAX_WIDTH) : width_ext;
  assign used_rows  = (height_ext > CH_W'(MAX_HEIGHT)) ? CH_W'(MAX_HEIGHT) : height_ext;

  // row of column cells, each exchanging its three rows with both neighbours
  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
    logic [2:0] left_in, right_in;

    assign col_use[c] = (CW_W'(c) < used_cols);
    assign wr_sel[c]  = (sel_col == CI_W'(c));

    if (c == 0) begin : g_left_edge
      assign left_in = 3'b000;
    end else begin : g_left
      assign left_in = nb_bits[c-1];
    end

    if (c == MAX_WIDTH - 1) begin : g_right_edge
      assign right_in = 3'b000;
    end else begin : g_right
      assign right_in = nb_bits[c+1];
    end

    life_cell #(
      .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .col_use  (col_use[c]),
      .wr_sel   (wr_sel[c]),
      .nb_left  (left_in),
      .nb_right (right_in),
      .nb_out   (nb_bits[c]),
      .head_bit (head_bits[c]),
      .change   (change_bits[c])
    );
  end

  // read port on the head row, and change flag across the row
  assign rd_bit     = head_bits[sel_col];
  assign any_change = |change_bits;

  life_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW_W       (CW_W),
    .CH_W       (CH_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_changed    (out_changed),
    .used_cols      (used_cols),
    .used_rows      (used_rows),
    .rd_bit         (rd_bit),
    .any_change     (any_change),
    .sel_col        (sel_col),
    .ctl            (ctl)
  );

endmodule

// ----- verif/life_cellular_automaton_board_tb.sv -----
// self-checking testbench for the life board: directed and random items against a board model
module life_cellular_automaton_board_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import life_pkg::*;

  localparam int BOARD_COLS     = DEF_MAX_WIDTH;
  localparam int BOARD_ROWS     = DEF_MAX_HEIGHT;
  localparam int RESET_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic read_value;
    logic changed;
  } cell_result_t;

  // block ports
  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = CFG_BOARD_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [ACTION_W-1:0]  in_action      = ACT_NOP;
  logic [ROW_W-1:0]     in_row         = '0;
  logic [COLUMN_W-1:0]  in_column      = '0;
  logic                 in_cell_value  = 1'b0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic                 out_read_value;
  logic                 out_changed;

  // board model and expected results
  bit             live_cells [BOARD_ROWS][BOARD_COLS];
  bit [CFG_W-1:0] model_width  = CFG_W'(CFG_SIZE_RESET);
  bit [CFG_W-1:0] model_height = CFG_W'(CFG_SIZE_RESET);
  cell_result_t   pending_results [$];

  // run control
  bit idling_on    = 1'b0;
  bit hold_req     = 1'b0;
  int fail_count   = 0;
  int hold_left    = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  life_cellular_automaton_board u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_changed    (out_changed)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sizes in use, clipped to the board limits
  function automatic int rows_in_use();
    return (model_height > BOARD_ROWS) ? BOARD_ROWS : int'(model_height);
  endfunction

  function automatic int cols_in_use();
    return (model_width > BOARD_COLS) ? BOARD_COLS : int'(model_width);
  endfunction

  // one generation of B3/S23 over the board in use, dead border around it
  function automatic bit advance_generation();
    bit prior [BOARD_ROWS][BOARD_COLS];
    int rows;
    int cols;
    int live_nb;
    bit next_cell;
    bit any_change;
    rows       = rows_in_use();
    cols       = cols_in_use();
    prior      = live_cells;
    any_change = 1'b0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        live_nb = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < rows &&
                c + dc >= 0 && c + dc < cols) begin
              live_nb += prior[r+dr][c+dc];
            end
          end
        end
        if (prior[r][c]) begin
          next_cell = (live_nb == STAY_COUNT) || (live_nb == BIRTH_COUNT);
        end else begin
          next_cell = (live_nb == BIRTH_COUNT);
        end
        if (next_cell != prior[r][c]) begin
          any_change = 1'b1;
        end
        live_cells[r][c] = next_cell;
      end
    end
    return any_change;
  endfunction

  // apply one item to the model and return what the block should report
  function automatic cell_result_t predict_result(action_t act, logic [ROW_W-1:0] r,
                                                  logic [COLUMN_W-1:0] c, logic v);
    cell_result_t res;
    bit           on_board;
    res.read_value = 1'b0;
    res.changed    = 1'b0;
    on_board       = (r < rows_in_use()) && (c < cols_in_use());
    case (act)
      ACT_WRITE: begin
        if (on_board) live_cells[r][c] = v;
      end
      ACT_READ: begin
        if (on_board) res.read_value = live_cells[r][c];
      end
      ACT_STEP: begin
        res.changed = advance_generation();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // offer one item, hold it until the transfer, then record the expectation
  task automatic send_item(action_t act, logic [ROW_W-1:0] r, logic [COLUMN_W-1:0] c,
                           logic v);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_row        <= r;
    in_column     <= c;
    in_cell_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(act, r, c, v));
  endtask

  // stop offering and wait until every result has been taken
  task automatic await_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // resize the board while it is idle
  task automatic set_board_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    await_all_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BOARD_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    model_width = w;
    cfg_index <= CFG_BOARD_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    model_height = h;
    cfg_wr_en <= 1'b0;
  endtask

  // mostly on-board writes, reads and steps, with some off-board and unused items
  task automatic send_random_items(int count);
    int                  pick;
    action_t             act;
    logic [ROW_W-1:0]    r;
    logic [COLUMN_W-1:0] c;
    logic                v;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) act = ACT_WRITE;
      else if (pick < 75) act = ACT_READ;
      else if (pick < 95) act = ACT_STEP;
      else act = ACT_NOP;
      if (rows_in_use() > 0 && cols_in_use() > 0 && $urandom_range(0, 6) != 0) begin
        r = ROW_W'($urandom_range(0, rows_in_use() - 1));
        c = COLUMN_W'($urandom_range(0, cols_in_use() - 1));
      end else begin
        r = ROW_W'($urandom);
        c = COLUMN_W'($urandom);
      end
      v = ($urandom_range(0, 9) < 7);
      send_item(act, r, c, v);
    end
  endtask

  // full board after reset: corners, lone cells dying, unused action
  task automatic test_reset_board();
    send_item(ACT_READ, 6'd0, 6'd0, 1'b1);
    send_item(ACT_READ, 6'd63, 6'd63, 1'b0);
    send_item(ACT_STEP, 6'd0, 6'd0, 1'b0);
    send_item(ACT_WRITE, 6'd63, 6'd63, 1'b1);
    send_item(ACT_READ, 6'd63, 6'd63, 1'b0);
    send_item(ACT_WRITE, 6'd0, 6'd0, 1'b1);
    send_item(ACT_NOP, 6'd63, 6'd63, 1'b1);
    send_item(ACT_STEP, 6'd63, 6'd63, 1'b1);
    send_item(ACT_READ, 6'd0, 6'd0, 1'b0);
  endtask

  // blinker on a 3 by 3 board pressed against the border, off-board access
  task automatic test_blinker_border();
    set_board_size(7'd3, 7'd3);
    send_item(ACT_WRITE, 6'd0, 6'd1, 1'b1);
    send_item(ACT_WRITE, 6'd1, 6'd1, 1'b1);
    send_item(ACT_WRITE, 6'd2, 6'd1, 1'b1);
    send_item(ACT_WRITE, 6'd5, 6'd5, 1'b1);
    send_item(ACT_READ, 6'd5, 6'd5, 1'b0);
    send_item(ACT_STEP, 6'd0, 6'd0, 1'b0);
    send_item(ACT_READ, 6'd1, 6'd0, 1'b0);
  endtask

  // no cell in use at all
  task automatic test_zero_size();
    set_board_size(7'd0, 7'd0);
    send_item(ACT_WRITE, 6'd0, 6'd0, 1'b1);
    send_item(ACT_READ, 6'd0, 6'd0, 1'b0);
    send_item(ACT_STEP, 6'd0, 6'd0, 1'b0);
  endtask

  // sizes above the limits act as the limits
  task automatic test_oversized_size();
    set_board_size(7'd127, 7'd127);
    send_item(ACT_READ, 6'd1, 6'd1, 1'b0);
    send_item(ACT_STEP, 6'd0, 6'd0, 1'b0);
    send_item(ACT_READ, 6'd63, 6'd0, 1'b0);
  endtask

  // random traffic over a spread of board shapes
  task automatic test_random_sizes();
    set_board_size(7'd7, 7'd6);
    send_random_items(20);
    set_board_size(7'd1, 7'd64);
    send_random_items(15);
    set_board_size(7'd64, 7'd1);
    send_random_items(15);
    set_board_size(7'($urandom_range(2, 20)), 7'($urandom_range(2, 20)));
    send_random_items(20);
    set_board_size(7'd127, 7'd9);
    send_random_items(15);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_hold_off();
    set_board_size(7'd8, 7'd8);
    hold_req <= 1'b1;
    send_random_items(12);
  endtask

  // sender waits for the board to empty mid-stream
  task automatic test_sender_pause();
    send_random_items(5);
    await_all_results();
    send_random_items(5);
  endtask

  // closing traffic at full size with no idling on either side
  task automatic test_final_unthrottled();
    idling_on = 1'b0;
    set_board_size(7'd64, 7'd64);
    send_random_items(20);
  endtask

  // receiver: long hold-off on request, otherwise random stall bursts
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("unexpected result: read_value=%b changed=%b", out_read_value,
                   out_changed);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value || out_changed !== want.changed) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch: read_value exp %b got %b, changed exp %b got %b",
                     want.read_value, out_read_value, want.changed, out_changed);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // reset, run the tests in turn, drain and report
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    idling_on = 1'b1;
    test_reset_board();
    test_blinker_border();
    test_zero_size();
    test_oversized_size();
    test_random_sizes();
    test_output_hold_off();
    test_sender_pause();
    test_final_unthrottled();
    await_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", pending_results.size());
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
